// ===== rtl/dcb_pkg.sv =====
`default_nettype none

package dcb_pkg;

   localparam int MAX_CHUNKS = 65536;
   localparam int WORD_BITS  = 64;
   localparam int MAP_WORDS  = MAX_CHUNKS / WORD_BITS;
   localparam int ADDR_W     = $clog2(MAP_WORDS);
   localparam int BIT_W      = $clog2(WORD_BITS);
   localparam int CHUNK_W    = ADDR_W + BIT_W;
   localparam int COUNT_W    = 17;
   localparam int OP_W       = 3;
   localparam int LANES      = WORD_BITS / 8;
   localparam int LANE_CNT_W = 4;
   localparam int POP_W      = $clog2(WORD_BITS + 1);

   localparam logic [COUNT_W-1:0] CHUNK_LIMIT = COUNT_W'(MAX_CHUNKS);

   localparam logic [OP_W-1:0] OP_MARK_RUN  = 3'd0;
   localparam logic [OP_W-1:0] OP_CLEAR_RUN = 3'd1;
   localparam logic [OP_W-1:0] OP_CHECK     = 3'd2;
   localparam logic [OP_W-1:0] OP_MARK_ALL  = 3'd3;
   localparam logic [OP_W-1:0] OP_CLEAR_ALL = 3'd4;

   typedef struct packed {
      logic load;
      logic walk_init;
      logic walk_issue;
      logic sweep_init;
      logic sweep_write;
      logic capture;
   } dcb_cmd_type;

   typedef struct packed {
      logic walk_needed;
      logic clear_all;
      logic walk_last;
      logic sweep_last;
      logic pipe_busy;
      logic out_free;
   } dcb_sts_type;

endpackage

`default_nettype wire

// ===== rtl/dcb_ctrl.sv =====
`default_nettype none

module dcb_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   input  logic                req_valid,
   output logic                req_ready,
   input  dcb_pkg::dcb_sts_type sts,
   output dcb_pkg::dcb_cmd_type cmd
);
   import dcb_pkg::*;

   localparam logic [2:0] ST_SWEEP_CFG = 3'd0;
   localparam logic [2:0] ST_IDLE      = 3'd1;
   localparam logic [2:0] ST_DECODE    = 3'd2;
   localparam logic [2:0] ST_SWEEP_OP  = 3'd3;
   localparam logic [2:0] ST_RUN       = 3'd4;
   localparam logic [2:0] ST_DRAIN     = 3'd5;
   localparam logic [2:0] ST_READ      = 3'd6;
   localparam logic [2:0] ST_FIN       = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_ready = (state_ff == ST_IDLE) && !csr_valid;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_SWEEP_CFG: begin
            cmd.sweep_write = 1'b1;
            if (sts.sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (sts.clear_all) begin
               cmd.sweep_init = 1'b1;
               state_in       = ST_SWEEP_OP;
            end else if (sts.walk_needed) begin
               cmd.walk_init = 1'b1;
               state_in      = ST_RUN;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_SWEEP_OP: begin
            cmd.sweep_write = 1'b1;
            if (sts.sweep_last) state_in = ST_READ;
         end
         ST_RUN: begin
            cmd.walk_issue = 1'b1;
            if (sts.walk_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            // Wait for the last word write and the count update to land.
            if (!sts.pipe_busy) state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (sts.out_free) begin
               cmd.capture = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // A new chunk count restarts the map from clean.
      if (csr_valid) begin
         cmd            = '0;
         cmd.sweep_init = 1'b1;
         state_in       = ST_SWEEP_CFG;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SWEEP_CFG;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/dcb_dpath.sv =====
`default_nettype none

module dcb_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   input  logic [dcb_pkg::COUNT_W-1:0]         csr_chunk_total,
   input  logic [dcb_pkg::OP_W-1:0]            req_op,
   input  logic [dcb_pkg::CHUNK_W-1:0]         req_first_chunk,
   input  logic [dcb_pkg::COUNT_W-1:0]         req_run_length,
   input  dcb_pkg::dcb_cmd_type                cmd,
   output dcb_pkg::dcb_sts_type                sts,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic                                rsp_first_is_dirty,
   output logic [dcb_pkg::COUNT_W-1:0]         rsp_dirty_total,
   output logic                                rsp_map_is_empty,
   output logic                                rsp_range_error
);
   import dcb_pkg::*;

   logic [COUNT_W-1:0]    chunk_total_ff;
   logic [OP_W-1:0]       op_ff;
   logic [CHUNK_W-1:0]    first_ff;
   logic [COUNT_W-1:0]    len_ff;

   logic [WORD_BITS-1:0]  mem [MAP_WORDS];
   logic [WORD_BITS-1:0]  rd_ff;
   logic [ADDR_W-1:0]     rd_addr;
   logic [ADDR_W-1:0]     wr_addr;
   logic [WORD_BITS-1:0]  wr_data;
   logic                  wr_en;

   logic [ADDR_W-1:0]     walk_ff;
   logic [ADDR_W-1:0]     sweep_ff;
   logic [ADDR_W-1:0]     p1_addr_ff;
   logic                  p1_ff;
   logic                  p2_ff;
   logic [LANE_CNT_W-1:0] lane_cnt_ff [LANES];
   logic [LANE_CNT_W-1:0] lane_cnt_in [LANES];
   logic [POP_W-1:0]      pop;
   logic [COUNT_W-1:0]    counter_ff;

   logic                  rsp_valid_ff;
   logic                  first_dirty_ff;
   logic [COUNT_W-1:0]    total_ff;
   logic                  empty_ff;
   logic                  error_ff;

   logic [COUNT_W-1:0]    n_eff;
   logic [COUNT_W:0]      run_end;
   logic                  first_in_map;
   logic                  run_op;
   logic                  mark_all;
   logic                  err;
   logic                  set_mode;
   logic [COUNT_W-1:0]    lo;
   logic [COUNT_W-1:0]    hi;
   logic [COUNT_W-1:0]    last;
   logic [ADDR_W-1:0]     lo_w;
   logic [ADDR_W-1:0]     last_w;
   logic [BIT_W-1:0]      lo_bit;
   logic [BIT_W-1:0]      hi_bit;
   logic [WORD_BITS-1:0]  mask;
   logic [WORD_BITS-1:0]  flip;
   logic [WORD_BITS-1:0]  new_word;

   // Request decode, from the captured request and the chunk count.
   assign n_eff        = (chunk_total_ff > CHUNK_LIMIT) ? CHUNK_LIMIT : chunk_total_ff;
   assign run_end      = {1'b0, COUNT_W'(first_ff)} + {1'b0, len_ff};
   assign first_in_map = COUNT_W'(first_ff) < n_eff;
   assign run_op       = (op_ff == OP_MARK_RUN) || (op_ff == OP_CLEAR_RUN);
   assign mark_all     = op_ff == OP_MARK_ALL;
   assign err          = (run_op && (!first_in_map || run_end > {1'b0, n_eff}))
                      || ((op_ff == OP_CHECK) && !first_in_map);
   assign set_mode     = op_ff != OP_CLEAR_RUN;
   assign lo           = mark_all ? '0 : COUNT_W'(first_ff);
   assign hi           = mark_all ? n_eff : run_end[COUNT_W-1:0];
   assign last         = hi - COUNT_W'(1);
   assign lo_w         = lo[CHUNK_W-1:BIT_W];
   assign last_w       = last[CHUNK_W-1:BIT_W];

   // Word update for the read that returned this cycle.
   assign lo_bit   = (p1_addr_ff == lo_w) ? lo[BIT_W-1:0] : '0;
   assign hi_bit   = (p1_addr_ff == last_w) ? last[BIT_W-1:0] : '1;
   assign mask     = ({WORD_BITS{1'b1}} << lo_bit)
                   & ({WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - hi_bit));
   assign flip     = set_mode ? (mask & ~rd_ff) : (mask & rd_ff);
   assign new_word = rd_ff ^ flip;

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         lane_cnt_in[l] = '0;
         for (int b = 0; b < 8; b++) begin
            lane_cnt_in[l] = lane_cnt_in[l] + LANE_CNT_W'(flip[l*8 + b]);
         end
      end
   end

   always_comb begin
      pop = '0;
      for (int l = 0; l < LANES; l++) begin
         pop = pop + POP_W'(lane_cnt_ff[l]);
      end
   end

   assign wr_en   = cmd.sweep_write | p1_ff;
   assign wr_addr = cmd.sweep_write ? sweep_ff : p1_addr_ff;
   assign wr_data = cmd.sweep_write ? '0 : new_word;
   assign rd_addr = cmd.walk_issue ? walk_ff : first_ff[CHUNK_W-1:BIT_W];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_total_ff <= CHUNK_LIMIT;
         sweep_ff       <= '0;
         counter_ff     <= '0;
         p1_ff          <= 1'b0;
         p2_ff          <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid) chunk_total_ff <= csr_chunk_total;
         if (cmd.sweep_init) begin
            sweep_ff <= '0;
         end else if (cmd.sweep_write) begin
            sweep_ff <= sweep_ff + ADDR_W'(1);
         end
         if (cmd.sweep_init) begin
            counter_ff <= '0;
         end else if (p2_ff) begin
            counter_ff <= set_mode ? counter_ff + COUNT_W'(pop)
                                   : counter_ff - COUNT_W'(pop);
         end
         p1_ff <= cmd.walk_issue;
         p2_ff <= p1_ff;
         if (cmd.capture) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_op;
         first_ff <= req_first_chunk;
         len_ff   <= req_run_length;
      end
      if (cmd.walk_init) begin
         walk_ff <= lo_w;
      end else if (cmd.walk_issue) begin
         walk_ff <= walk_ff + ADDR_W'(1);
      end
      p1_addr_ff  <= walk_ff;
      lane_cnt_ff <= lane_cnt_in;
      if (cmd.capture) begin
         first_dirty_ff <= first_in_map && rd_ff[first_ff[BIT_W-1:0]];
         total_ff       <= counter_ff;
         empty_ff       <= counter_ff == '0;
         error_ff       <= err;
      end
   end

   assign sts.walk_needed = (run_op && !err && (len_ff != '0)) || (mark_all && (n_eff != '0));
   assign sts.clear_all   = op_ff == OP_CLEAR_ALL;
   assign sts.walk_last   = walk_ff == last_w;
   assign sts.sweep_last  = sweep_ff == '1;
   assign sts.pipe_busy   = p1_ff | p2_ff;
   assign sts.out_free    = !rsp_valid_ff || rsp_ready;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_first_is_dirty = first_dirty_ff;
   assign rsp_dirty_total    = total_ff;
   assign rsp_map_is_empty   = empty_ff;
   assign rsp_range_error    = error_ff;

endmodule

`default_nettype wire

// ===== rtl/dirty_chunk_bitmap.sv =====
// Channel  Direction  Words carry
// req      in         op, first_chunk, run_length
// rsp      out        first_is_dirty, dirty_total, map_is_empty, range_error
// csr      in         chunk_total (write also clears the map)
//
// A check or rejected request passes through the decode, read and finish states between accepts.
// A run touching k bitmap words walks them in address order; the bitmap memory
// updates one word per cycle through a read-modify-write pipeline.
// Mark all walks every word up to the chunk count; clear all sweeps all 1024 words.
// After reset or a chunk_total write, a clearing pass over all 1024 words holds req_ready low.
// A result held by rsp_ready low stalls only the finish of the next request.
`default_nettype none

module dirty_chunk_bitmap (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [dcb_pkg::OP_W-1:0]    req_op,
   input  logic [dcb_pkg::CHUNK_W-1:0] req_first_chunk,
   input  logic [dcb_pkg::COUNT_W-1:0] req_run_length,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_first_is_dirty,
   output logic [dcb_pkg::COUNT_W-1:0] rsp_dirty_total,
   output logic                        rsp_map_is_empty,
   output logic                        rsp_range_error,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [dcb_pkg::COUNT_W-1:0] csr_chunk_total
);
   import dcb_pkg::*;

   dcb_cmd_type cmd;
   dcb_sts_type sts;

   assign csr_ready = 1'b1;

   dcb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   dcb_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_chunk_total    (csr_chunk_total),
      .req_op             (req_op),
      .req_first_chunk    (req_first_chunk),
      .req_run_length     (req_run_length),
      .cmd                (cmd),
      .sts                (sts),
      .rsp_ready          (rsp_ready),
      .rsp_valid          (rsp_valid),
      .rsp_first_is_dirty (rsp_first_is_dirty),
      .rsp_dirty_total    (rsp_dirty_total),
      .rsp_map_is_empty   (rsp_map_is_empty),
      .rsp_range_error    (rsp_range_error)
   );

endmodule

`default_nettype wire

// ===== rtl/dcb_checker.sv =====
`default_nettype none

module dcb_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic [dcb_pkg::OP_W-1:0]    req_op,
   input logic [dcb_pkg::CHUNK_W-1:0] req_first_chunk,
   input logic [dcb_pkg::COUNT_W-1:0] req_run_length,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        rsp_first_is_dirty,
   input logic [dcb_pkg::COUNT_W-1:0] rsp_dirty_total,
   input logic                        rsp_map_is_empty,
   input logic                        rsp_range_error,
   input logic                        csr_valid,
   input logic                        csr_ready,
   input logic [dcb_pkg::COUNT_W-1:0] csr_chunk_total
);
   import dcb_pkg::*;

   // The clearing pass starts right out of reset, with no word offered.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("request or response open right after reset");

   // One request at a time: an accepted word closes the request side.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request side still open after an accept");

   a_empty_matches_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_map_is_empty == (rsp_dirty_total == '0))
      else $error("empty flag disagrees with dirty count");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_dirty_total <= CHUNK_LIMIT)
      else $error("dirty count beyond chunk limit");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_dirty_total)
         && $stable(rsp_first_is_dirty) && $stable(rsp_range_error))
      else $error("stalled response word changed");

endmodule

bind dirty_chunk_bitmap dcb_checker u_dcb_checker (.*);

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import dcb_pkg::*;

   localparam int unsigned CYCLE_LIMIT    = 2_000_000;
   localparam int unsigned SQUEEZE_AFTER  = 200;
   localparam int unsigned SQUEEZE_CYCLES = 600;
   localparam int unsigned REPORT_LIMIT   = 10;

   // Op codes the block does not define; they must leave the map alone.
   localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
   localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [CHUNK_W-1:0] first;
      logic [COUNT_W-1:0] len;
   } bitmap_req_type;

   typedef struct packed {
      logic               first_is_dirty;
      logic [COUNT_W-1:0] dirty_total;
      logic               map_is_empty;
      logic               range_error;
   } bitmap_status_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [OP_W-1:0]    req_op = OP_CHECK;
   logic [CHUNK_W-1:0] req_first_chunk = '0;
   logic [COUNT_W-1:0] req_run_length = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_first_is_dirty;
   logic [COUNT_W-1:0] rsp_dirty_total;
   logic               rsp_map_is_empty;
   logic               rsp_range_error;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [COUNT_W-1:0] csr_chunk_total = '0;

   bitmap_req_type     req_backlog[$];
   bitmap_req_type     next_req;
   bitmap_status_type  status_due[$];

   bit                 chunk_map[MAX_CHUNKS];
   int unsigned        dirty_tally;
   int unsigned        chunk_total_shadow;

   int unsigned        reqs_taken = 0;
   int unsigned        bad_results = 0;
   int unsigned        cycles = 0;
   int unsigned        send_gap = 0;
   int unsigned        take_gap = 0;
   int unsigned        squeeze_left = 0;
   bit                 squeeze_done = 1'b0;
   bit                 send_calm = 1'b0;
   bit                 take_calm = 1'b0;

   dirty_chunk_bitmap DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_op             (req_op),
      .req_first_chunk    (req_first_chunk),
      .req_run_length     (req_run_length),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_first_is_dirty (rsp_first_is_dirty),
      .rsp_dirty_total    (rsp_dirty_total),
      .rsp_map_is_empty   (rsp_map_is_empty),
      .rsp_range_error    (rsp_range_error),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_chunk_total    (csr_chunk_total)
   );

   always #5 clock = ~clock;

   function automatic int unsigned tracked_chunks(input int unsigned total);
      return (total > MAX_CHUNKS) ? MAX_CHUNKS : total;
   endfunction

   function automatic void wipe_map();
      foreach (chunk_map[i]) chunk_map[i] = 1'b0;
      dirty_tally = 0;
   endfunction

   function automatic void paint_chunks(input int unsigned lo, input int unsigned cnt,
                                        input bit dirty);
      for (int unsigned c = lo; c < lo + cnt; c++) begin
         if (chunk_map[c] != dirty) begin
            chunk_map[c] = dirty;
            if (dirty) dirty_tally++;
            else dirty_tally--;
         end
      end
   endfunction

   function automatic bitmap_status_type apply_request(input logic [OP_W-1:0] op,
                                                       input logic [CHUNK_W-1:0] first,
                                                       input logic [COUNT_W-1:0] len);
      bitmap_status_type s;
      int unsigned       n;
      int unsigned       f;
      int unsigned       l;
      bit                err;
      n   = tracked_chunks(chunk_total_shadow);
      f   = 32'(first);
      l   = 32'(len);
      err = 1'b0;
      case (op)
         OP_MARK_RUN, OP_CLEAR_RUN: begin
            if (f >= n || f + l > n) err = 1'b1;
            else paint_chunks(f, l, op == OP_MARK_RUN);
         end
         OP_CHECK:     err = (f >= n);
         OP_MARK_ALL:  paint_chunks(0, n, 1'b1);
         OP_CLEAR_ALL: wipe_map();
         default: ;
      endcase
      s.first_is_dirty = (f < n) && chunk_map[f];
      s.dirty_total    = dirty_tally[COUNT_W-1:0];
      s.map_is_empty   = (dirty_tally == 0);
      s.range_error    = err;
      return s;
   endfunction

   function automatic int unsigned draw_gap(input bit calm);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 60);
   endfunction

   task automatic queue_req(input logic [OP_W-1:0] op, input logic [CHUNK_W-1:0] first,
                            input logic [COUNT_W-1:0] len);
      bitmap_req_type r;
      r.op    = op;
      r.first = first;
      r.len   = len;
      req_backlog.push_back(r);
   endtask

   // Most traffic lands in a hot window so that checks and clears meet dirty chunks.
   task automatic queue_random_reqs(input int unsigned count, input int unsigned n_eff);
      int unsigned     span;
      int unsigned     lo;
      int unsigned     f;
      int unsigned     room;
      int unsigned     roll;
      int unsigned     l;
      logic [OP_W-1:0] run_op;
      span = (n_eff < 1024) ? n_eff : 1024;
      lo   = (n_eff == 0) ? 0 : $urandom_range(0, n_eff - span);
      repeat (count) begin
         roll = $urandom_range(0, 99);
         if (n_eff == 0) f = $urandom_range(0, MAX_CHUNKS - 1);
         else if ($urandom_range(0, 3) == 0) f = $urandom_range(0, n_eff - 1);
         else f = lo + $urandom_range(0, span - 1);
         room = (f < n_eff) ? n_eff - f : 0;
         l = $urandom_range(1, 160);
         if (l > room) l = room;
         run_op = ($urandom_range(0, 1) != 0) ? OP_CLEAR_RUN : OP_MARK_RUN;
         if (roll < 32) queue_req(OP_MARK_RUN, CHUNK_W'(f), COUNT_W'(l));
         else if (roll < 55) queue_req(OP_CLEAR_RUN, CHUNK_W'(f), COUNT_W'(l));
         else if (roll < 77)
            queue_req(OP_CHECK, CHUNK_W'(f), COUNT_W'($urandom_range(0, 17'h1FFFF)));
         else if (roll < 85)
            queue_req(run_op, CHUNK_W'($urandom_range(0, 16'hFFFF)),
                      COUNT_W'($urandom_range(0, 17'h1FFFF)));
         else if (roll < 89)
            queue_req(run_op, CHUNK_W'(f), COUNT_W'(room + $urandom_range(1, 8)));
         else if (roll < 92) queue_req(run_op, CHUNK_W'(f), 0);
         else if (roll < 95)
            queue_req(OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)),
                      CHUNK_W'($urandom), COUNT_W'($urandom));
         else if (roll < 96) queue_req(OP_MARK_ALL, CHUNK_W'(f), COUNT_W'($urandom));
         else if (roll < 97) queue_req(OP_CLEAR_ALL, CHUNK_W'(f), COUNT_W'($urandom));
         else queue_req(run_op, CHUNK_W'(f), COUNT_W'(room));
      end
   endtask

   task automatic wait_drained();
      while (req_backlog.size() != 0 || req_valid || status_due.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_chunk_total(input logic [COUNT_W-1:0] total);
      csr_chunk_total <= total;
      csr_valid       <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      // A resized map starts clean.
      chunk_total_shadow = 32'(total);
      wipe_map();
   endtask

   task automatic check_status();
      bitmap_status_type want;
      bitmap_status_type got;
      got.first_is_dirty = rsp_first_is_dirty;
      got.dirty_total    = rsp_dirty_total;
      got.map_is_empty   = rsp_map_is_empty;
      got.range_error    = rsp_range_error;
      if (status_due.size() == 0) begin
         bad_results++;
         if (bad_results <= REPORT_LIMIT)
            $display("%0t: result word with nothing outstanding:", $realtime,
                     " dirty=%0b total=%0d empty=%0b err=%0b",
                     got.first_is_dirty, got.dirty_total, got.map_is_empty,
                     got.range_error);
      end else begin
         want = status_due.pop_front();
         if (got.first_is_dirty !== want.first_is_dirty ||
             got.dirty_total    !== want.dirty_total ||
             got.map_is_empty   !== want.map_is_empty ||
             got.range_error    !== want.range_error) begin
            bad_results++;
            if (bad_results <= REPORT_LIMIT)
               $display("%0t: mismatch: expected dirty=%0b total=%0d empty=%0b err=%0b,",
                        $realtime, want.first_is_dirty, want.dirty_total,
                        want.map_is_empty, want.range_error,
                        " got dirty=%0b total=%0d empty=%0b err=%0b",
                        got.first_is_dirty, got.dirty_total,
                        got.map_is_empty, got.range_error);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            status_due.push_back(apply_request(req_op, req_first_chunk, req_run_length));
            reqs_taken++;
            send_gap = draw_gap(send_calm);
         end
         if (!req_valid || req_ready) begin
            if (send_gap != 0 || req_backlog.size() == 0) begin
               if (send_gap != 0) send_gap--;
               req_valid <= 1'b0;
            end else begin
               next_req = req_backlog.pop_front();
               req_valid       <= 1'b1;
               req_op          <= next_req.op;
               req_first_chunk <= next_req.first;
               req_run_length  <= next_req.len;
            end
         end
      end
   end

   // Once during the run the receiver holds off long enough for the block to back up
   // into its request channel.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         take_gap = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            check_status();
            take_gap = draw_gap(take_calm);
         end
         if (!squeeze_done && reqs_taken >= SQUEEZE_AFTER) begin
            squeeze_done = 1'b1;
            squeeze_left = SQUEEZE_CYCLES;
         end
         if (squeeze_left != 0) begin
            squeeze_left--;
            rsp_ready <= 1'b0;
         end else if (take_gap != 0) begin
            take_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      logic [COUNT_W-1:0] chunk_settings[8];
      int unsigned        n_eff;
      chunk_settings = '{17'd1, 17'd0, 17'h1FFFF, 17'd64, 17'd77, 17'd5000, 17'h10000, 17'd1};
      chunk_settings[7] = COUNT_W'($urandom_range(1, MAX_CHUNKS));
      chunk_total_shadow = MAX_CHUNKS;
      wipe_map();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed requests against the full-size map left by reset.
      queue_req(OP_CHECK, 0, 0);
      queue_req(OP_MARK_RUN, 0, 1);
      queue_req(OP_MARK_RUN, 16'hFFFF, 1);
      queue_req(OP_CHECK, 16'hFFFF, 0);
      queue_req(OP_MARK_RUN, 60, 10);
      queue_req(OP_CLEAR_RUN, 62, 3);
      queue_req(OP_CHECK, 63, 0);
      queue_req(OP_MARK_RUN, 100, 0);
      queue_req(OP_MARK_RUN, 16'hFFFA, 7);
      queue_req(OP_CLEAR_RUN, 0, 17'h1FFFF);
      queue_req(OP_MARK_RUN, 0, 17'h10000);
      queue_req(OP_CLEAR_RUN, 1, 17'h0FFFF);
      queue_req(OP_CHECK, 0, 0);
      queue_req(OP_CLEAR_ALL, 16'h1234, 17'h1FFFF);
      queue_req(OP_MARK_RUN, 16'h5555, 17'h0AAAA);
      queue_req(OP_CHECK, 16'hAAAA, 0);
      queue_req(OP_MARK_ALL, 16'hFFFF, 17'h1FFFF);
      queue_req(OP_CLEAR_RUN, 16'hAAAA, 17'h05555);
      for (int op = int'(OP_UNUSED_LO); op <= int'(OP_UNUSED_HI); op++)
         queue_req(OP_W'(op), CHUNK_W'($urandom), COUNT_W'($urandom));
      queue_req(OP_CLEAR_ALL, 0, 0);
      queue_req(OP_CHECK, 16'h5555, 0);
      queue_random_reqs(500, tracked_chunks(chunk_total_shadow));
      wait_drained();

      foreach (chunk_settings[i]) begin
         send_calm = ($urandom_range(0, 3) == 0);
         take_calm = ($urandom_range(0, 3) == 0);
         write_chunk_total(chunk_settings[i]);
         n_eff = tracked_chunks(chunk_total_shadow);
         queue_req(OP_MARK_ALL, 0, 0);
         queue_req(OP_CHECK, CHUNK_W'((n_eff == 0) ? 0 : n_eff - 1), 0);
         queue_req(OP_CHECK, CHUNK_W'(n_eff), 0);
         queue_random_reqs(175, n_eff);
         wait_drained();
      end

      repeat (100) @(posedge clock);
      if (bad_results == 0 && status_due.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
